// ===== rtl/core/ipp_pkg.sv =====
// Shared types, character codes and decode helpers for the address text parser.
// No dependencies; imported by every module of the parser core.
package ipp_pkg;

    // Sizes of the parsed address forms
    localparam int GROUP_COUNT = 8;
    localparam int GROUP_W     = 16;
    localparam int ADDR_W      = GROUP_COUNT * GROUP_W;
    localparam int OCTET_W     = 8;
    localparam int QUAD_W      = 4 * OCTET_W;
    localparam int GCOUNT_W    = 4;
    localparam int GDIGIT_W    = 3;
    localparam int ACC_W       = 12;

    // Numeric limits
    localparam logic [ACC_W-1:0]    OCTET_MAX  = 12'd255;
    localparam logic [ACC_W-1:0]    ZONE_SAT   = 12'd255;
    localparam logic [7:0]          ZONE_MAX   = 8'd254;
    localparam logic [7:0]          DEC_RADIX  = 8'd10;
    localparam logic [GCOUNT_W-1:0] GROUPS_ALL = 4'd8;
    localparam logic [GCOUNT_W-1:0] GROUPS_GAP = 4'd7;
    localparam logic [GDIGIT_W-1:0] GROUP_DIGITS_MAX = 3'd4;
    localparam logic [1:0]          DOTS_ALL   = 2'd3;

    // Character codes
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;

    // IPv6 scanner phases
    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_LEAD     = 3'd1,
        PH_GROUP    = 3'd2,
        PH_COLON    = 3'd3,
        PH_AFTERGAP = 3'd4,
        PH_ZSTART   = 3'd5,
        PH_ZONE     = 3'd6
    } ipp_phase_t;

    // One character moving from the input register into the checkers
    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] character;
    } ipp_item_t;

    // IPv4 verdict for the string ending at this character
    typedef struct packed {
        logic              ok;
        logic [QUAD_W-1:0] addr;
    } ipp_quad_res_t;

    // IPv6 verdict for the string ending at this character
    typedef struct packed {
        logic                ok;
        logic [ADDR_W/2-1:0] high;
        logic [ADDR_W/2-1:0] low;
        logic [7:0]          zone;
    } ipp_hex_res_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [3:0] dec_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return d[3:0];
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_dec(c)) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
            d = c - CH_LO_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            d = c - CH_UP_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ===== rtl/core/ip_address_text_parser_core.sv =====
// Top level of the address text parser: input register, both checkers, result register.
// Depends on ipp_pkg, ipp_quad and ipp_hex.
//
// Usage:
//   Send the address text on the s_ channel, one character per item, with
//   s_last high on the final character. Both channels are valid/ready.
//   One result item leaves on the m_ channel for each string: m_valid_res
//   says whether the text parsed, m_is_ipv6 selects the form, and the
//   address and zone fields are zero where they do not apply.
// Flow:
//   A character is taken into the input register and applied to the
//   checkers from there, so one character per cycle is sustained while
//   no final character waits on a busy result register. m_valid comes
//   from the result register, loaded when the final character moves on.
// Reset:
//   aresetn (synchronous, active low) clears both checkers and empties the
//   input and result registers; no clearing pass is needed.
// Stall:
//   While a result waits on m_ready, characters that do not end a string
//   still flow in; a final character waits in the input register until the
//   result register frees, and s_ready drops only then.
module ip_address_text_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic        m_is_ipv6,
    output logic [63:0] m_address_high,
    output logic [63:0] m_address_low,
    output logic [7:0]  m_zone_code
);
    import ipp_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_last_reg;
    logic          out_valid_reg;
    logic          res_valid_reg;
    logic          res_ipv6_reg;
    logic [63:0]   res_high_reg;
    logic [63:0]   res_low_reg;
    logic [7:0]    res_zone_reg;

    logic          advance;
    logic          load_out;
    ipp_item_t     item;
    ipp_quad_res_t quad_res;
    ipp_hex_res_t  hex_res;
    logic          use_hex;

    // A held character moves on unless it closes a string and the result slot is busy
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign load_out = advance && in_last_reg;
    assign s_ready  = !in_valid_reg || advance;

    assign item.step      = advance;
    assign item.last      = in_last_reg;
    assign item.character = in_char_reg;

    ipp_quad u_quad (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .res     (quad_res)
    );

    ipp_hex u_hex (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .res     (hex_res)
    );

    // IPv4 wins when both forms pass
    assign use_hex = hex_res.ok && !quad_res.ok;

    // Capture an incoming item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_character;
            in_last_reg <= s_last;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            res_valid_reg <= quad_res.ok || hex_res.ok;
            res_ipv6_reg  <= use_hex;
            res_high_reg  <= use_hex ? hex_res.high : 64'd0;
            res_low_reg   <= quad_res.ok ? {32'd0, quad_res.addr} :
                             (use_hex ? hex_res.low : 64'd0);
            res_zone_reg  <= use_hex ? hex_res.zone : 8'd0;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_valid_res    = res_valid_reg;
    assign m_is_ipv6      = res_ipv6_reg;
    assign m_address_high = res_high_reg;
    assign m_address_low  = res_low_reg;
    assign m_zone_code    = res_zone_reg;

    // Input side stalls only behind a final character blocked by a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked final character");

    // Results come only from final characters
    assert property (@(posedge aclk) disable iff (!aresetn)
        !load_out |=> (out_valid_reg == $past(out_valid_reg && !m_ready)))
        else $error("result appeared or vanished without a final character");

    // An IPv6 result is always a successful parse
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_ipv6_reg) |-> res_valid_reg)
        else $error("IPv6 flag on a failed parse");

    // A failed parse carries all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_valid_reg) |->
            (res_high_reg == 64'd0 && res_low_reg == 64'd0 && res_zone_reg == 8'd0))
        else $error("failed parse with nonzero fields");

    // An IPv4 result uses only the low 32 address bits and no zone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_valid_reg && !res_ipv6_reg) |->
            (res_high_reg == 64'd0 && res_low_reg[63:32] == 32'd0 && res_zone_reg == 8'd0))
        else $error("IPv4 result with stray bits");

endmodule

// ===== rtl/core/ipp_quad.sv =====
// Dotted-quad IPv4 checker: octet accumulator, dot counter and failure flag.
// Depends on ipp_pkg.
module ipp_quad (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ipp_pkg::ipp_item_t     item,
    output ipp_pkg::ipp_quad_res_t res
);
    import ipp_pkg::*;

    logic [3*OCTET_W-1:0] octets_reg, octets_next;
    logic [OCTET_W-1:0]   value_reg, value_next;
    logic                 have_reg, have_next;
    logic [1:0]           dots_reg, dots_next;
    logic                 failed_reg, failed_next;
    logic [ACC_W-1:0]     acc;

    // Apply the current character to the octet state
    always_comb begin
        octets_next = octets_reg;
        value_next  = value_reg;
        have_next   = have_reg;
        dots_next   = dots_reg;
        failed_next = failed_reg;
        acc = {{(ACC_W-4){1'b0}}, dec_val(item.character)};
        if (have_reg) begin
            acc = ACC_W'(value_reg) * ACC_W'(DEC_RADIX) + acc;
        end
        if (!failed_reg) begin
            if (is_dec(item.character)) begin
                if (acc > OCTET_MAX) begin
                    failed_next = 1'b1;
                end else begin
                    value_next = acc[OCTET_W-1:0];
                    have_next  = 1'b1;
                end
            end else if (item.character == CH_DOT) begin
                if ((dots_reg == DOTS_ALL) || !have_reg) begin
                    failed_next = 1'b1;
                end else begin
                    octets_next = {octets_reg[2*OCTET_W-1:0], value_reg};
                    dots_next   = dots_reg + 2'd1;
                    value_next  = '0;
                    have_next   = 1'b0;
                end
            end else begin
                failed_next = 1'b1;
            end
        end
    end

    // Verdict as if this character closes the string
    always_comb begin
        res.ok   = !failed_next && (dots_next == DOTS_ALL) && have_next;
        res.addr = {octets_next, value_next};
    end

    // Hold state between characters, clear after the final one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octets_reg <= '0;
            value_reg  <= '0;
            have_reg   <= 1'b0;
            dots_reg   <= '0;
            failed_reg <= 1'b0;
        end else if (item.step) begin
            if (item.last) begin
                octets_reg <= '0;
                value_reg  <= '0;
                have_reg   <= 1'b0;
                dots_reg   <= '0;
                failed_reg <= 1'b0;
            end else begin
                octets_reg <= octets_next;
                value_reg  <= value_next;
                have_reg   <= have_next;
                dots_reg   <= dots_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

// ===== rtl/core/ipp_hex.sv =====
// IPv6 checker: phase sequencer, group shift line, gap split and zone decoder.
// Depends on ipp_pkg.
module ipp_hex (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipp_pkg::ipp_item_t    item,
    output ipp_pkg::ipp_hex_res_t res
);
    import ipp_pkg::*;

    ipp_phase_t            phase_reg, phase_next;
    logic [ADDR_W-1:0]     tail_reg, tail_next;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [GCOUNT_W-1:0]   count_reg, count_next;
    logic [GROUP_W-1:0]    value_reg, value_next;
    logic [GDIGIT_W-1:0]   digits_reg, digits_next;
    logic                  gap_reg, gap_next;
    logic [7:0]            zone_reg, zone_next;
    logic                  failed_reg, failed_next;

    logic [4:0]            hx;
    logic [ACC_W-1:0]      zacc;
    logic                  fin_commit;
    logic                  fin_fail;
    logic [ADDR_W-1:0]     fin_tail;
    logic [ADDR_W-1:0]     fin_addr;
    logic [GCOUNT_W-1:0]   fin_count;
    logic                  fin_phase_ok;
    logic                  fin_count_ok;
    logic                  fin_zone_ok;
    logic [GCOUNT_W-1:0]   head_shift;

    assign hx = hex_of(item.character);
    // Groups still missing when the double colon is seen move the head to the top
    assign head_shift = GROUPS_ALL - count_reg;

    // Advance the scanner by one character
    always_comb begin
        phase_next  = phase_reg;
        tail_next   = tail_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        value_next  = value_reg;
        digits_next = digits_reg;
        gap_next    = gap_reg;
        zone_next   = zone_reg;
        failed_next = failed_reg;
        zacc = {{(ACC_W-4){1'b0}}, dec_val(item.character)};
        if (phase_reg == PH_ZONE) begin
            zacc = ACC_W'(zone_reg) * ACC_W'(DEC_RADIX) + zacc;
        end
        if (!failed_reg) begin
            unique case (phase_reg)
                PH_START: begin
                    if (item.character == CH_COLON) begin
                        phase_next = PH_LEAD;
                    end else if (hx[4]) begin
                        value_next  = {{(GROUP_W-4){1'b0}}, hx[3:0]};
                        digits_next = 3'd1;
                        phase_next  = PH_GROUP;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_LEAD: begin
                    if (item.character == CH_COLON) begin
                        gap_next   = 1'b1;
                        phase_next = PH_AFTERGAP;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_GROUP: begin
                    if (hx[4]) begin
                        if (digits_reg >= GROUP_DIGITS_MAX) begin
                            failed_next = 1'b1;
                        end else begin
                            value_next  = {value_reg[GROUP_W-5:0], hx[3:0]};
                            digits_next = digits_reg + 3'd1;
                        end
                    end else if ((item.character == CH_COLON) ||
                                 (item.character == CH_PERCENT)) begin
                        if (count_reg >= GROUPS_ALL) begin
                            failed_next = 1'b1;
                        end else begin
                            tail_next   = {tail_reg[ADDR_W-GROUP_W-1:0], value_reg};
                            count_next  = count_reg + 4'd1;
                            value_next  = '0;
                            digits_next = '0;
                        end
                        phase_next = (item.character == CH_COLON) ? PH_COLON : PH_ZSTART;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_COLON: begin
                    if (item.character == CH_COLON) begin
                        if (gap_reg) begin
                            failed_next = 1'b1;
                        end else begin
                            gap_next   = 1'b1;
                            head_next  = tail_reg << {head_shift, 4'b0000};
                            tail_next  = '0;
                            phase_next = PH_AFTERGAP;
                        end
                    end else if (hx[4]) begin
                        if (count_reg >= GROUPS_ALL) begin
                            failed_next = 1'b1;
                        end else begin
                            value_next  = {{(GROUP_W-4){1'b0}}, hx[3:0]};
                            digits_next = 3'd1;
                            phase_next  = PH_GROUP;
                        end
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_AFTERGAP: begin
                    if (hx[4]) begin
                        if (count_reg >= GROUPS_ALL) begin
                            failed_next = 1'b1;
                        end else begin
                            value_next  = {{(GROUP_W-4){1'b0}}, hx[3:0]};
                            digits_next = 3'd1;
                            phase_next  = PH_GROUP;
                        end
                    end else if (item.character == CH_PERCENT) begin
                        phase_next = PH_ZSTART;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_ZSTART, PH_ZONE: begin
                    if (is_dec(item.character)) begin
                        zone_next  = (zacc > ZONE_SAT) ? 8'hff : zacc[7:0];
                        phase_next = PH_ZONE;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                default: begin
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    // Close an open group and judge the string as if it ends here
    always_comb begin
        fin_commit   = !failed_next && (phase_next == PH_GROUP);
        fin_fail     = fin_commit && (count_next >= GROUPS_ALL);
        fin_tail     = tail_next;
        fin_count    = count_next;
        if (fin_commit && !fin_fail) begin
            fin_tail  = {tail_next[ADDR_W-GROUP_W-1:0], value_next};
            fin_count = count_next + 4'd1;
        end
        fin_phase_ok = (phase_next == PH_GROUP) || (phase_next == PH_AFTERGAP) ||
                       (phase_next == PH_ZONE);
        fin_count_ok = gap_next ? (fin_count <= GROUPS_GAP) : (fin_count == GROUPS_ALL);
        fin_zone_ok  = !((phase_next == PH_ZONE) && (zone_next > ZONE_MAX));
        fin_addr     = head_next | fin_tail;
        res.ok   = !failed_next && !fin_fail && fin_phase_ok && fin_count_ok && fin_zone_ok;
        res.high = fin_addr[ADDR_W-1:ADDR_W/2];
        res.low  = fin_addr[ADDR_W/2-1:0];
        res.zone = (phase_next == PH_ZONE) ? zone_next + 8'd1 : 8'd0;
    end

    // Hold scanner state between characters, clear after the final one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            tail_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            value_reg  <= '0;
            digits_reg <= '0;
            gap_reg    <= 1'b0;
            zone_reg   <= '0;
            failed_reg <= 1'b0;
        end else if (item.step) begin
            if (item.last) begin
                phase_reg  <= PH_START;
                tail_reg   <= '0;
                head_reg   <= '0;
                count_reg  <= '0;
                value_reg  <= '0;
                digits_reg <= '0;
                gap_reg    <= 1'b0;
                zone_reg   <= '0;
                failed_reg <= 1'b0;
            end else begin
                phase_reg  <= phase_next;
                tail_reg   <= tail_next;
                head_reg   <= head_next;
                count_reg  <= count_next;
                value_reg  <= value_next;
                digits_reg <= digits_next;
                gap_reg    <= gap_next;
                zone_reg   <= zone_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

// ===== verif/ipp_verdict_checker.sv =====
// Checker for the address text parser: mirrors the IPv4 and IPv6 parse of every item
// taken on the s_ channel and compares each m_ channel result with the predicted verdict.
// Depends on ipp_pkg for the scanner phases and the character codes.
`timescale 1ns / 100ps

module ipp_verdict_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_valid_res,
    input  logic        m_is_ipv6,
    input  logic [63:0] m_address_high,
    input  logic [63:0] m_address_low,
    input  logic [7:0]  m_zone_code,
    output int          error_count,
    output int          pending_count
);
    import ipp_pkg::*;

    typedef struct packed {
        logic        valid_res;
        logic        is_ipv6;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  zone_code;
    } verdict_t;

    // verdicts of finished strings, oldest first
    verdict_t verdict_q[$];

    // dotted-quad side
    logic [7:0]  oct_done [0:2];
    logic [7:0]  oct_acc;
    logic        oct_seen;
    logic [1:0]  dot_cnt;
    logic        quad_bad;

    // hex side
    logic [15:0] grp [0:7];
    logic [3:0]  grp_cnt;
    logic [15:0] grp_acc;
    logic [2:0]  grp_len;
    logic [3:0]  gap_at;
    logic        gap_found;
    ipp_phase_t  phase;
    logic [7:0]  zone_acc;
    logic        hex_bad;

    initial begin
        error_count   = 0;
        pending_count = 0;
    end

    function automatic int dec_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        return -1;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    // Return both scanners to the start of a string
    task automatic clear_parse();
        for (int i = 0; i < 3; i++) oct_done[i] = '0;
        for (int i = 0; i < 8; i++) grp[i] = '0;
        oct_acc   = '0;
        oct_seen  = 1'b0;
        dot_cnt   = '0;
        quad_bad  = 1'b0;
        grp_cnt   = '0;
        grp_acc   = '0;
        grp_len   = '0;
        gap_at    = '0;
        gap_found = 1'b0;
        phase     = PH_START;
        zone_acc  = '0;
        hex_bad   = 1'b0;
    endtask

    // Advance the dotted-quad scan by one character
    task automatic quad_take(input logic [7:0] c);
        int d;
        int v;
        d = dec_digit(c);
        if (quad_bad) return;
        if (d >= 0) begin
            v = oct_seen ? int'(oct_acc) * 10 + d : d;
            if (v > 255) begin
                quad_bad = 1'b1;
            end else begin
                oct_acc  = 8'(v);
                oct_seen = 1'b1;
            end
        end else if (c == CH_DOT) begin
            if (dot_cnt == DOTS_ALL || !oct_seen) begin
                quad_bad = 1'b1;
            end else begin
                oct_done[dot_cnt] = oct_acc;
                dot_cnt  = dot_cnt + 2'd1;
                oct_acc  = '0;
                oct_seen = 1'b0;
            end
        end else begin
            quad_bad = 1'b1;
        end
    endtask

    task automatic open_group(input int d);
        if (grp_cnt >= GROUPS_ALL) begin
            hex_bad = 1'b1;
        end else begin
            grp_acc = 16'(d);
            grp_len = 3'd1;
            phase   = PH_GROUP;
        end
    endtask

    task automatic close_group();
        if (grp_cnt >= GROUPS_ALL) begin
            hex_bad = 1'b1;
        end else begin
            grp[grp_cnt[2:0]] = grp_acc;
            grp_cnt = grp_cnt + 4'd1;
            grp_acc = '0;
            grp_len = '0;
        end
    endtask

    // Advance the hex scan by one character
    task automatic hex_take(input logic [7:0] c);
        int d;
        int z;
        int v;
        d = hex_digit(c);
        z = dec_digit(c);
        if (hex_bad) return;
        case (phase)
            PH_START: begin
                if (c == CH_COLON) phase = PH_LEAD;
                else if (d >= 0) open_group(d);
                else hex_bad = 1'b1;
            end
            PH_LEAD: begin
                if (c == CH_COLON) begin
                    gap_found = 1'b1;
                    gap_at    = '0;
                    phase     = PH_AFTERGAP;
                end else begin
                    hex_bad = 1'b1;
                end
            end
            PH_GROUP: begin
                if (d >= 0) begin
                    if (grp_len >= GROUP_DIGITS_MAX) begin
                        hex_bad = 1'b1;
                    end else begin
                        grp_acc = {grp_acc[11:0], 4'(d)};
                        grp_len = grp_len + 3'd1;
                    end
                end else if (c == CH_COLON) begin
                    close_group();
                    phase = PH_COLON;
                end else if (c == CH_PERCENT) begin
                    close_group();
                    phase = PH_ZSTART;
                end else begin
                    hex_bad = 1'b1;
                end
            end
            PH_COLON: begin
                if (c == CH_COLON) begin
                    if (gap_found) begin
                        hex_bad = 1'b1;
                    end else begin
                        gap_found = 1'b1;
                        gap_at    = grp_cnt;
                        phase     = PH_AFTERGAP;
                    end
                end else if (d >= 0) begin
                    open_group(d);
                end else begin
                    hex_bad = 1'b1;
                end
            end
            PH_AFTERGAP: begin
                if (d >= 0) open_group(d);
                else if (c == CH_PERCENT) phase = PH_ZSTART;
                else hex_bad = 1'b1;
            end
            PH_ZSTART, PH_ZONE: begin
                if (z >= 0) begin
                    v = (phase == PH_ZONE) ? int'(zone_acc) * 10 : 0;
                    v = v + z;
                    zone_acc = (v > 255) ? 8'd255 : 8'(v);
                    phase    = PH_ZONE;
                end else begin
                    hex_bad = 1'b1;
                end
            end
            default: hex_bad = 1'b1;
        endcase
    endtask

    // Close the string: queue its verdict and start over
    task automatic end_string();
        verdict_t    r;
        logic        ok;
        int          missing;
        logic [15:0] g;
        r = '0;
        if (!quad_bad && dot_cnt == DOTS_ALL && oct_seen) begin
            r.valid_res   = 1'b1;
            r.address_low = {32'd0, oct_done[0], oct_done[1], oct_done[2], oct_acc};
        end else begin
            if (!hex_bad && phase == PH_GROUP) close_group();
            if (!hex_bad && (phase == PH_GROUP || phase == PH_AFTERGAP || phase == PH_ZONE)) begin
                ok = gap_found ? (grp_cnt <= GROUPS_GAP && gap_at <= grp_cnt)
                               : (grp_cnt == GROUPS_ALL);
                if (phase == PH_ZONE && zone_acc > ZONE_MAX) ok = 1'b0;
                if (ok) begin
                    missing = 8 - int'(grp_cnt);
                    for (int i = 0; i < 8; i++) begin
                        if (!gap_found || i < int'(gap_at)) g = grp[i];
                        else if (i < int'(gap_at) + missing) g = '0;
                        else g = grp[i - missing];
                        if (i < 4) r.address_high = {r.address_high[47:0], g};
                        else r.address_low = {r.address_low[47:0], g};
                    end
                    r.valid_res = 1'b1;
                    r.is_ipv6   = 1'b1;
                    r.zone_code = (phase == PH_ZONE) ? zone_acc + 8'd1 : 8'd0;
                end
            end
        end
        verdict_q.push_back(r);
        clear_parse();
    endtask

    task automatic check_field(input string label, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare results, then fold in the item taken at this edge
    always @(posedge aclk) begin
        verdict_t exp_r;
        if (!aresetn) begin
            clear_parse();
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with no string pending, actual %b %b %h %h %h",
                             $time, m_valid_res, m_is_ipv6, m_address_high, m_address_low,
                             m_zone_code);
                    error_count++;
                end else begin
                    exp_r = verdict_q.pop_front();
                    check_field("valid_res", 64'(exp_r.valid_res), 64'(m_valid_res));
                    check_field("is_ipv6", 64'(exp_r.is_ipv6), 64'(m_is_ipv6));
                    check_field("address_high", exp_r.address_high, m_address_high);
                    check_field("address_low", exp_r.address_low, m_address_low);
                    check_field("zone_code", 64'(exp_r.zone_code), 64'(m_zone_code));
                end
            end
            if (s_valid && s_ready) begin
                quad_take(s_character);
                hex_take(s_character);
                if (s_last) end_string();
            end
        end
        pending_count = verdict_q.size();
    end

endmodule

// ===== verif/tb_ip_address_text_parser_core.sv =====
// Testbench top for the address text parser core: drives address strings one character
// per item with random idling on both channels and gives the verdict.
// Depends on ip_address_text_parser_core and ipp_verdict_checker.
`timescale 1ns / 100ps

module tb_ip_address_text_parser_core;

    localparam int STALL_LIMIT = 2000;
    localparam int CHAR_TARGET = 1550;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_character;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic        m_valid_res;
    logic        m_is_ipv6;
    logic [63:0] m_address_high;
    logic [63:0] m_address_low;
    logic [7:0]  m_zone_code;
    int          error_count;
    int          pending_count;

    // characters of the string being built
    logic [7:0] text_q[$];
    // stretch with no idling on either side
    bit         calm;
    int         sent_chars;
    int         idle_cycles;

    string corner_texts[] = '{
        "0.0.0.0", "255.255.255.255", "256.1.1.1", "1..2.3", "001.02.3.4", "1.2.3.4.",
        "::", "::1", "1::", "ffff:FFFF:0:0:0:0:0:abcd", "1:2:3:4:5:6:7:8:9",
        "1:2:3:4::5:6:7:8", ":1::2", "1::2:", ":::", "1::2::3", "12345::",
        "fe80::1%0", "fe80::1%254", "fe80::1%255", "fe80::1%99999", "fe80::1%",
        "fe80::1% 1", "fe80::1%+1", "::%7"
    };

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    ip_address_text_parser_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_is_ipv6      (m_is_ipv6),
        .m_address_high (m_address_high),
        .m_address_low  (m_address_low),
        .m_zone_code    (m_zone_code)
    );

    ipp_verdict_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_is_ipv6      (m_is_ipv6),
        .m_address_high (m_address_high),
        .m_address_low  (m_address_low),
        .m_zone_code    (m_zone_code),
        .error_count    (error_count),
        .pending_count  (pending_count)
    );

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_syntax_char();
        string pool;
        pool = ":.%0123456789afAFg +-";
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Send the built string, last on its final character
    task automatic send_text();
        int gap;
        for (int i = 0; i < text_q.size(); i++) begin
            gap = calm ? 0 : pick_gap();
            if (gap > 0) begin
                @(negedge aclk) s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            s_valid     <= 1'b1;
            s_character <= text_q[i];
            s_last      <= (i == text_q.size() - 1);
            do @(posedge aclk); while (s_ready !== 1'b1);
        end
        sent_chars += text_q.size();
        text_q.delete();
    endtask

    task automatic add_octet();
        int    r;
        int    v;
        string s;
        r = $urandom_range(0, 99);
        if (r < 70) v = $urandom_range(0, 255);
        else if (r < 82) v = $urandom_range(0, 9);
        else if (r < 90) v = 255;
        else v = $urandom_range(256, 999);
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0) s = {"0", s};
        add_text(s);
    endtask

    task automatic add_quad();
        for (int k = 0; k < 4; k++) begin
            add_octet();
            if (k < 3) add_text(".");
        end
    endtask

    task automatic add_group();
        string lo_set;
        string up_set;
        int    n;
        int    d;
        lo_set = "0123456789abcdef";
        up_set = "0123456789ABCDEF";
        n = ($urandom_range(0, 29) == 0) ? 5 : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            d = $urandom_range(0, 15);
            text_q.push_back($urandom_range(0, 1) ? lo_set[d] : up_set[d]);
        end
    endtask

    task automatic add_groups(input int n);
        for (int i = 0; i < n; i++) begin
            add_group();
            if (i < n - 1) add_text(":");
        end
    endtask

    task automatic add_hex();
        int n;
        int left;
        int r;
        if ($urandom_range(0, 9) < 6) begin
            n = ($urandom_range(0, 19) == 0) ? 8 : $urandom_range(0, 7);
            left = $urandom_range(0, n);
            add_groups(left);
            add_text("::");
            add_groups(n - left);
        end else begin
            r = $urandom_range(0, 19);
            n = (r == 0) ? 7 : (r == 1) ? 9 : 8;
            add_groups(n);
        end
        // optional zone
        if ($urandom_range(0, 9) < 3) begin
            add_text("%");
            r = $urandom_range(0, 19);
            if (r < 12) add_text($sformatf("%0d", $urandom_range(0, 254)));
            else if (r < 14) add_text($sformatf("00%0d", $urandom_range(0, 254)));
            else if (r < 16) add_text("254");
            else if (r < 18) add_text($sformatf("%0d", $urandom_range(255, 99999)));
            else if (r == 18) add_text("%");
        end
    endtask

    // Generated quad or hex text with one or two edits
    task automatic add_mutant();
        int pos;
        if ($urandom_range(0, 1)) add_quad();
        else add_hex();
        repeat ($urandom_range(1, 2)) begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 2))
                0: text_q[pos] = pick_syntax_char();
                1: text_q.insert(pos, pick_syntax_char());
                default: begin
                    if (text_q.size() > 1) text_q.delete(pos);
                end
            endcase
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 8)) text_q.push_back(pick_syntax_char());
    endtask

    // Result side: stall at random, or stay ready in a calm stretch
    initial begin
        int  hold;
        bit  rdy;
        hold = 0;
        rdy  = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                rdy  = ($urandom_range(0, 99) < 65);
                hold = rdy ? $urandom_range(1, 8) : pick_gap();
                m_ready <= rdy;
            end
        end
    end

    // Stop a hung run: count cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_ip_address_text_parser_core: errors");
            $finish;
        end
    end

    initial begin
        int n_strings;
        int r;
        s_valid     = 1'b0;
        s_character = '0;
        s_last      = 1'b0;
        m_ready     = 1'b0;
        aresetn     = 1'b0;
        calm        = 1'b0;
        sent_chars  = 0;
        idle_cycles = 0;
        n_strings   = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // corner strings
        foreach (corner_texts[i]) begin
            add_text(corner_texts[i]);
            send_text();
        end
        // zero byte inside otherwise valid text
        add_text("1.2.3.4");
        text_q.push_back(8'h00);
        send_text();
        add_text("::");
        text_q.push_back(8'h00);
        add_text("1");
        send_text();

        // random strings, mostly well formed
        while (sent_chars < CHAR_TARGET) begin
            if (n_strings % 16 == 0) calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 40) add_hex();
            else if (r < 65) add_quad();
            else if (r < 87) add_mutant();
            else add_noise();
            send_text();
            n_strings++;
        end
        calm = 1'b0;
        @(negedge aclk) s_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_ip_address_text_parser_core: clean");
        end else begin
            $display("tb_ip_address_text_parser_core: errors");
        end
        $finish;
    end

endmodule

// ===== ip_address_text_parser_core.f =====
rtl/core/ipp_pkg.sv
rtl/core/ipp_quad.sv
rtl/core/ipp_hex.sv
rtl/core/ip_address_text_parser_core.sv
verif/ipp_verdict_checker.sv
verif/tb_ip_address_text_parser_core.sv
